[sv/assert_macros.svh]
// Assertion helpers used by rf_pulse_packet_decoder_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[sv/rppd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppd_pkg
// Types and constants of the RF pulse packet decoder.
// ----------------------------------------------------------------------------
package rppd_pkg;

  localparam int SHIFT_BITS_DEF = 32;

  localparam int DUR_W   = 16;
  localparam int COUNT_W = 6;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_MID = 3'd0,
    REG_PULSE_MAX = 3'd1,
    REG_PULSE_MIN = 3'd2,
    REG_COUNT_MIN = 3'd3,
    REG_COUNT_MAX = 3'd4
  } reg_idx_t;

  localparam logic [DUR_W-1:0]   PULSE_MID_RST = 16'd1300;
  localparam logic [DUR_W-1:0]   PULSE_MAX_RST = 16'd1850;
  localparam logic [DUR_W-1:0]   PULSE_MIN_RST = 16'd650;
  localparam logic [COUNT_W-1:0] COUNT_MIN_RST = 6'd36;
  localparam logic [COUNT_W-1:0] COUNT_MAX_RST = 6'd52;
  localparam logic [COUNT_W-1:0] COUNT_SAT     = 6'd63;

  localparam logic [3:0] PREAMBLE      = 4'hE;
  localparam logic [1:0] CHECK_SEED    = 2'h3;

  localparam logic [5:0] LF_OFF  = 6'h16;
  localparam logic [5:0] LF_ON   = 6'h02;
  localparam logic [5:0] LF_UP   = 6'h00;
  localparam logic [5:0] LF_DOWN = 6'h04;

  typedef enum logic [2:0] {
    CMD_OFF   = 3'd0,
    CMD_ON    = 3'd1,
    CMD_UP    = 3'd2,
    CMD_DOWN  = 3'd3,
    CMD_LEVEL = 3'd4
  } cmd_t;

  // packet status seen by the decode stage (after the current pulse)
  typedef struct packed {
    logic timing_error;
    logic await_second_short;
    logic count_ok;
  } pkt_status_t;

  typedef struct packed {
    logic        decoded_ok;
    logic [13:0] system_unit_code;
    logic [5:0]  level_fade;
    logic [2:0]  command_code;
    logic [3:0]  dim_level;
  } result_t;

endpackage

[sv/rppd_pulse_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppd_pulse_if
// Pulse channel: one pulse duration per item, with an end-of-packet mark.
// ----------------------------------------------------------------------------
interface rppd_pulse_if;
  logic        valid;
  logic        ready;
  logic [15:0] pulse_duration;
  logic        last_pulse;

  modport source (output valid, output pulse_duration, output last_pulse, input ready);
  modport sink   (input valid, input pulse_duration, input last_pulse, output ready);
endinterface

[sv/rppd_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppd_result_if
// Result channel: one decoded packet per item.
// ----------------------------------------------------------------------------
interface rppd_result_if;
  logic        valid;
  logic        ready;
  logic        decoded_ok;
  logic [13:0] system_unit_code;
  logic [5:0]  level_fade;
  logic [2:0]  command_code;
  logic [3:0]  dim_level;

  modport source (output valid, output decoded_ok, output system_unit_code,
                  output level_fade, output command_code, output dim_level,
                  input ready);
  modport sink   (input valid, input decoded_ok, input system_unit_code,
                  input level_fade, input command_code, input dim_level,
                  output ready);
endinterface

[sv/rppd_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppd_decode
// Packet check and command classification from the shifted bit stream.
// ----------------------------------------------------------------------------
module rppd_decode
  import rppd_pkg::*;
#(
  parameter int SHIFT_BITS = SHIFT_BITS_DEF
) (
  input  logic [SHIFT_BITS-1:0] bit_shift,
  input  pkt_status_t           status,
  output result_t               result
);

  logic [13:0] sysunit;
  logic [1:0]  ck1;
  logic [5:0]  lf;
  logic [1:0]  ck2;
  logic [1:0]  fold1;
  logic [1:0]  fold2;
  logic        ok;
  cmd_t        cmd;
  logic [3:0]  lvl;

  assign sysunit = bit_shift[23:10];
  assign ck1     = bit_shift[9:8];
  assign lf      = bit_shift[7:2];
  assign ck2     = bit_shift[1:0];

  always_comb begin
    fold1 = CHECK_SEED;
    for (int i = 0; i < 7; i++) begin
      fold1 = fold1 ^ sysunit[2*i +: 2];
    end
    fold2 = CHECK_SEED;
    for (int i = 0; i < 3; i++) begin
      fold2 = fold2 ^ lf[2*i +: 2];
    end
  end

  assign ok = !status.timing_error && !status.await_second_short && status.count_ok
              && (bit_shift != '0) && (bit_shift[27:24] == PREAMBLE)
              && (ck1 == fold1) && (ck2 == fold2);

  always_comb begin
    lvl = '0;
    priority if (lf == LF_ON) begin
      cmd = CMD_ON;
    end else if (lf == LF_OFF) begin
      cmd = CMD_OFF;
    end else if (lf == LF_UP) begin
      cmd = CMD_UP;
    end else if (lf == LF_DOWN) begin
      cmd = CMD_DOWN;
    end else begin
      cmd = CMD_LEVEL;
      lvl = {lf[2], lf[3], lf[4], lf[5]};
    end
  end

  always_comb begin
    result = '0;
    if (ok) begin
      result.decoded_ok       = 1'b1;
      result.system_unit_code = sysunit;
      result.level_fade       = lf;
      result.command_code     = cmd;
      result.dim_level        = lvl;
    end
  end

endmodule

[sv/rf_pulse_packet_decoder_core.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rf_pulse_packet_decoder_core
// Decodes pulse-width coded RF packets, one pulse per item.
// ----------------------------------------------------------------------------
// channel   direction  payload
// pulse     in         pulse_duration[15:0], last_pulse
// result    out        decoded_ok, system_unit_code[13:0], level_fade[5:0],
//                      command_code[2:0], dim_level[3:0]
// cfg       in         cfg_we, cfg_index[2:0], cfg_data[15:0]
//
// One pulse per cycle when not stalled. A last pulse puts its result in the
// output register on the accepting edge; it is visible the next cycle.
// The input stalls only while the output register holds an untaken result.
// rst (synchronous) clears packet state and restores register defaults.
// ----------------------------------------------------------------------------
module rf_pulse_packet_decoder_core
  import rppd_pkg::*;
#(
  parameter int SHIFT_BITS = SHIFT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  rppd_pulse_if.sink           pulse,
  rppd_result_if.source        result
);

  logic [DUR_W-1:0]   pulse_mid;
  logic [DUR_W-1:0]   pulse_max;
  logic [DUR_W-1:0]   pulse_min;
  logic [COUNT_W-1:0] count_min;
  logic [COUNT_W-1:0] count_max;

  logic [SHIFT_BITS-1:0] bit_shift, bit_shift_next;
  logic [COUNT_W-1:0]    pulse_count, pulse_count_next;
  logic                  await_second_short, await_second_short_next;
  logic                  timing_error, timing_error_next;

  logic        out_valid;
  result_t     out_data;
  result_t     decoded;
  pkt_status_t status;
  logic        in_accept;
  logic        dur_long;
  logic        dur_short_bad;

  assign pulse.ready = !out_valid || result.ready;
  assign in_accept   = pulse.valid && pulse.ready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_mid <= PULSE_MID_RST;
      pulse_max <= PULSE_MAX_RST;
      pulse_min <= PULSE_MIN_RST;
      count_min <= COUNT_MIN_RST;
      count_max <= COUNT_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PULSE_MID: pulse_mid <= cfg_data;
        REG_PULSE_MAX: pulse_max <= cfg_data;
        REG_PULSE_MIN: pulse_min <= cfg_data;
        REG_COUNT_MIN: count_min <= cfg_data[COUNT_W-1:0];
        REG_COUNT_MAX: count_max <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign dur_long      = pulse.pulse_duration > pulse_mid;
  assign dur_short_bad = pulse.pulse_duration < pulse_min;

  // per-pulse state update; the first pulse of a packet only counts
  always_comb begin
    bit_shift_next          = bit_shift;
    await_second_short_next = await_second_short;
    timing_error_next       = timing_error;
    if (pulse_count != '0) begin
      if (await_second_short) begin
        timing_error_next       = timing_error || dur_long || dur_short_bad;
        bit_shift_next          = {bit_shift[SHIFT_BITS-2:0], 1'b1};
        await_second_short_next = 1'b0;
      end else if (dur_long) begin
        timing_error_next = timing_error || (pulse.pulse_duration > pulse_max);
        bit_shift_next    = {bit_shift[SHIFT_BITS-2:0], 1'b0};
      end else begin
        timing_error_next       = timing_error || dur_short_bad;
        await_second_short_next = 1'b1;
      end
    end
    pulse_count_next = (pulse_count == COUNT_SAT) ? pulse_count : pulse_count + 1'b1;
  end

  assign status.timing_error       = timing_error_next;
  assign status.await_second_short = await_second_short_next;
  assign status.count_ok = (pulse_count_next >= count_min) && (pulse_count_next <= count_max);

  rppd_decode #(
    .SHIFT_BITS(SHIFT_BITS)
  ) u_decode (
    .bit_shift(bit_shift_next),
    .status   (status),
    .result   (decoded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_shift          <= '0;
      pulse_count        <= '0;
      await_second_short <= 1'b0;
      timing_error       <= 1'b0;
    end else if (in_accept) begin
      if (pulse.last_pulse) begin
        bit_shift          <= '0;
        pulse_count        <= '0;
        await_second_short <= 1'b0;
        timing_error       <= 1'b0;
      end else begin
        bit_shift          <= bit_shift_next;
        pulse_count        <= pulse_count_next;
        await_second_short <= await_second_short_next;
        timing_error       <= timing_error_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && pulse.last_pulse) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && pulse.last_pulse) begin
      out_data <= decoded;
    end
  end

  assign result.valid            = out_valid;
  assign result.decoded_ok       = out_data.decoded_ok;
  assign result.system_unit_code = out_data.system_unit_code;
  assign result.level_fade       = out_data.level_fade;
  assign result.command_code     = out_data.command_code;
  assign result.dim_level        = out_data.dim_level;

  `ASSERT_NXT(a_last_clears, clk, rst, in_accept && pulse.last_pulse, (pulse_count == '0) && !await_second_short && !timing_error && result.valid)
  `ASSERT_IMP(a_no_overwrite, clk, rst, out_valid && !result.ready, !pulse.ready)
  `ASSERT_IMP(a_fail_zero, clk, rst, out_valid && !out_data.decoded_ok, (out_data.system_unit_code == '0) && (out_data.level_fade == '0) && (out_data.command_code == CMD_OFF) && (out_data.dim_level == '0))
  `ASSERT_IMP(a_dim_only_level, clk, rst, out_valid && (out_data.dim_level != '0), out_data.command_code == CMD_LEVEL)

endmodule

[dv/rf_pulse_packet_decoder_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_pulse_packet_decoder_core_tb
// Self-checking bench for the RF pulse packet decoder. Pulse trains are
// encoded from random packet words, some with injected faults, plus random
// noise trains. A scoreboard decodes each accepted pulse alongside the block
// and compares every result field. It runs through several register settings
// and several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module rf_pulse_packet_decoder_core_tb;
  import rppd_pkg::*;

  localparam int SB          = SHIFT_BITS_DEF;
  localparam int SETTLE_CYC  = 4;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum int {FLAW_NONE, FLAW_BIT, FLAW_TIMING, FLAW_UNPAIRED} flaw_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  rppd_pulse_if  pulse_ch ();
  rppd_result_if result_ch ();

  rf_pulse_packet_decoder_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pulse     (pulse_ch),
    .result    (result_ch)
  );

  // scoreboard copy of the registers and packet state
  logic [15:0]   cfg_mid, cfg_max, cfg_min;
  logic [5:0]    cfg_cmin, cfg_cmax;
  logic [SB-1:0] sb_shift;
  logic [5:0]    sb_count;
  logic          sb_half_one;
  logic          sb_timing_err;

  result_t expected_q[$];
  result_t want_r;

  int errors       = 0;
  int results_seen = 0;
  int pulses_sent  = 0;
  int cycle_count  = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [1:0] xor_pairs(input logic [13:0] v, input int pairs);
    logic [1:0] c;
    c = CHECK_SEED;
    for (int i = 0; i < pairs; i++) c ^= v[2*i +: 2];
    return c;
  endfunction

  task automatic clear_packet_state();
    sb_shift      = '0;
    sb_count      = '0;
    sb_half_one   = 1'b0;
    sb_timing_err = 1'b0;
  endtask

  // advance the scoreboard by one accepted pulse; queue a result on last
  task automatic decode_pulse(input logic [15:0] dur, input logic last);
    logic [13:0] su;
    logic [5:0]  lf;
    logic        ok;
    result_t     r;
    if (sb_count != 0) begin
      if (sb_half_one) begin
        if (dur > cfg_mid || dur < cfg_min) sb_timing_err = 1'b1;
        sb_shift    = {sb_shift[SB-2:0], 1'b1};
        sb_half_one = 1'b0;
      end else if (dur > cfg_mid) begin
        if (dur > cfg_max) sb_timing_err = 1'b1;
        sb_shift = {sb_shift[SB-2:0], 1'b0};
      end else begin
        if (dur < cfg_min) sb_timing_err = 1'b1;
        sb_half_one = 1'b1;
      end
    end
    if (sb_count != COUNT_SAT) sb_count = sb_count + 6'd1;
    if (last) begin
      su = sb_shift[23:10];
      lf = sb_shift[7:2];
      ok = !sb_timing_err && !sb_half_one
        && sb_count >= cfg_cmin && sb_count <= cfg_cmax
        && sb_shift != '0 && sb_shift[27:24] == PREAMBLE
        && sb_shift[9:8] == xor_pairs(su, 7)
        && sb_shift[1:0] == xor_pairs({8'd0, lf}, 3);
      r = '0;
      if (ok) begin
        r.decoded_ok       = 1'b1;
        r.system_unit_code = su;
        r.level_fade       = lf;
        case (lf)
          LF_ON:   r.command_code = CMD_ON;
          LF_OFF:  r.command_code = CMD_OFF;
          LF_UP:   r.command_code = CMD_UP;
          LF_DOWN: r.command_code = CMD_DOWN;
          default: begin
            r.command_code = CMD_LEVEL;
            r.dim_level    = {lf[2], lf[3], lf[4], lf[5]};
          end
        endcase
      end
      expected_q.push_back(r);
      clear_packet_state();
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result item with no packet pending");
          errors++;
        end else begin
          want_r = expected_q.pop_front();
          check_field("decoded_ok", 16'(want_r.decoded_ok), 16'(result_ch.decoded_ok));
          check_field("system_unit_code", 16'(want_r.system_unit_code),
                      16'(result_ch.system_unit_code));
          check_field("level_fade", 16'(want_r.level_fade), 16'(result_ch.level_fade));
          check_field("command_code", 16'(want_r.command_code),
                      16'(result_ch.command_code));
          check_field("dim_level", 16'(want_r.dim_level), 16'(result_ch.dim_level));
        end
        results_seen++;
      end
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [15:0] long_pulse();
    if ($urandom_range(7) == 0) return (cfg_max > cfg_mid) ? cfg_max : cfg_mid + 16'd1;
    if (cfg_max > cfg_mid) return 16'($urandom_range(cfg_max, cfg_mid + 16'd1));
    if (cfg_mid != 16'hFFFF) return 16'($urandom_range(65535, cfg_mid + 16'd1));
    return 16'hFFFF;
  endfunction

  function automatic logic [15:0] short_pulse();
    if (cfg_min > cfg_mid) return 16'($urandom_range(cfg_mid, 0));
    if ($urandom_range(7) == 0) return ($urandom_range(1) != 0) ? cfg_min : cfg_mid;
    return 16'($urandom_range(cfg_mid, cfg_min));
  endfunction

  task automatic send_pulse(input logic [15:0] dur, input logic last);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      pulse_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    pulse_ch.valid          <= 1'b1;
    pulse_ch.pulse_duration <= dur;
    pulse_ch.last_pulse     <= last;
    do @(posedge clk); while (!pulse_ch.ready);
    pulses_sent++;
    decode_pulse(dur, last);
  endtask

  task automatic send_train(input logic [15:0] durs[$]);
    foreach (durs[i]) send_pulse(durs[i], i == durs.size() - 1);
  endtask

  // hold the sender until every pending packet has been decoded
  task automatic drain();
    pulse_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] mid, mx, mn, input logic [5:0] cmin, cmax);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_PULSE_MID;
    cfg_data  <= mid;
    @(posedge clk);
    cfg_index <= REG_PULSE_MAX;
    cfg_data  <= mx;
    @(posedge clk);
    cfg_index <= REG_PULSE_MIN;
    cfg_data  <= mn;
    @(posedge clk);
    // upper bits of the count registers are don't-care
    cfg_index <= REG_COUNT_MIN;
    cfg_data  <= {10'($urandom), cmin};
    @(posedge clk);
    cfg_index <= REG_COUNT_MAX;
    cfg_data  <= {10'($urandom), cmax};
    @(posedge clk);
    cfg_we   <= 1'b0;
    cfg_mid  = mid;
    cfg_max  = mx;
    cfg_min  = mn;
    cfg_cmin = cmin;
    cfg_cmax = cmax;
  endtask

  // encode a packet word as a pulse train, optionally with one fault
  task automatic send_packet(input logic [13:0] su, input logic [5:0] lf, input int lead,
                             input flaw_t flaw);
    logic [27:0] word;
    logic        bit_seq[$];
    logic [15:0] durs[$];
    int          pos;
    word = {PREAMBLE, su, xor_pairs(su, 7), lf, xor_pairs({8'd0, lf}, 3)};
    if (flaw == FLAW_BIT) begin
      pos       = $urandom_range(27);
      word[pos] = ~word[pos];
    end
    repeat (lead) bit_seq.push_back(1'($urandom_range(1)));
    for (int i = 27; i >= 0; i--) bit_seq.push_back(word[i]);
    durs.push_back(16'($urandom_range(65535)));
    foreach (bit_seq[i]) begin
      if (bit_seq[i]) begin
        durs.push_back(short_pulse());
        durs.push_back(short_pulse());
      end else begin
        durs.push_back(long_pulse());
      end
    end
    if (flaw == FLAW_TIMING) begin
      pos       = $urandom_range(durs.size() - 1, 1);
      durs[pos] = 16'($urandom_range(65535));
    end
    if (flaw == FLAW_UNPAIRED) durs.push_back(short_pulse());
    send_train(durs);
  endtask

  task automatic send_noise();
    logic [15:0] durs[$];
    int          len;
    len = $urandom_range(20, 1);
    repeat (len) begin
      case ($urandom_range(2))
        0:       durs.push_back(16'($urandom_range(65535)));
        1:       durs.push_back(short_pulse());
        default: durs.push_back(long_pulse());
      endcase
    end
    send_train(durs);
  endtask

  task automatic send_random_packet();
    logic [5:0] lf;
    flaw_t      flaw;
    int         lead;
    if ($urandom_range(9) >= 7) begin
      send_noise();
    end else begin
      case ($urandom_range(5))
        0:       lf = LF_OFF;
        1:       lf = LF_ON;
        2:       lf = LF_UP;
        3:       lf = LF_DOWN;
        default: lf = 6'($urandom_range(63));
      endcase
      case ($urandom_range(9))
        0:       flaw = FLAW_BIT;
        1:       flaw = FLAW_TIMING;
        2:       flaw = FLAW_UNPAIRED;
        default: flaw = FLAW_NONE;
      endcase
      lead = ($urandom_range(9) == 0) ? $urandom_range(40, 5) : $urandom_range(4);
      send_packet(14'($urandom_range(16383)), lf, lead, flaw);
    end
  endtask

  // single-pulse packet, unpaired final short, timing faults, duration bounds
  task automatic test_edge_pulses();
    send_train('{16'd0});
    send_train('{16'hFFFF, 16'hFFFF, PULSE_MID_RST});
    send_train('{16'd1, PULSE_MID_RST + 16'd1, PULSE_MAX_RST, PULSE_MAX_RST + 16'd1,
                 PULSE_MIN_RST - 16'd1, PULSE_MIN_RST});
    send_train('{16'd100, PULSE_MIN_RST, PULSE_MID_RST, 16'd0, 16'd0});
  endtask

  task automatic test_commands();
    send_packet(14'h0000, LF_OFF, 0, FLAW_NONE);
    send_packet(14'h3FFF, LF_ON, 0, FLAW_NONE);
    send_packet(14'h1A5C, LF_UP, 0, FLAW_NONE);
    send_packet(14'h2C31, LF_DOWN, 0, FLAW_NONE);
    send_packet(14'h0F0F, 6'h3F, 0, FLAW_NONE);
    send_packet(14'h3001, 6'h29, 0, FLAW_NONE);
  endtask

  // count saturation and the extreme count windows
  task automatic test_count_limits();
    set_config(PULSE_MID_RST, PULSE_MAX_RST, PULSE_MIN_RST, 6'd0, COUNT_SAT);
    send_packet(14'h2A55, LF_ON, 40, FLAW_NONE);
    set_config(PULSE_MID_RST, PULSE_MAX_RST, PULSE_MIN_RST, COUNT_SAT, COUNT_SAT);
    send_packet(14'h15AA, 6'h11, 40, FLAW_NONE);
    send_packet(14'h15AA, 6'h11, 0, FLAW_NONE);
    set_config(PULSE_MID_RST, PULSE_MAX_RST, PULSE_MIN_RST, 6'd0, 6'd0);
    send_train('{16'd700});
    send_packet(14'h0001, LF_OFF, 0, FLAW_NONE);
  endtask

  task automatic test_random(input int n_pulses, input int n_results,
                             input int send_pct, input int recv_pct);
    int start_pulses;
    int start_results;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start_pulses   = pulses_sent;
    start_results  = results_seen;
    while (pulses_sent - start_pulses < n_pulses || results_seen - start_results < n_results)
      send_random_packet();
  endtask

  initial begin
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = REG_PULSE_MID;
    cfg_data                = '0;
    pulse_ch.valid          = 1'b0;
    pulse_ch.pulse_duration = '0;
    pulse_ch.last_pulse     = 1'b0;
    cfg_mid  = PULSE_MID_RST;
    cfg_max  = PULSE_MAX_RST;
    cfg_min  = PULSE_MIN_RST;
    cfg_cmin = COUNT_MIN_RST;
    cfg_cmax = COUNT_MAX_RST;
    clear_packet_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edge_pulses();
    test_commands();
    test_count_limits();

    set_config(PULSE_MID_RST, PULSE_MAX_RST, PULSE_MIN_RST, COUNT_MIN_RST, COUNT_MAX_RST);
    test_random(60, 1, 0, 0);
    set_config(16'd32767, 16'hFFFF, 16'd0, 6'd0, COUNT_SAT);
    test_random(60, 1, 75, 0);
    set_config(16'd2000 + 16'($urandom_range(2000)), 16'd4001 + 16'($urandom_range(2000)),
               16'($urandom_range(2000)), 6'($urandom_range(40)), 6'($urandom_range(63, 40)));
    test_random(60, 1, 0, 75);
    set_config(16'd0, 16'd0, 16'd0, 6'd0, 6'd0);
    test_random(60, 1, 17, 17);
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, COUNT_SAT, COUNT_SAT);
    test_random(60, 1, 17, 17);
    set_config(PULSE_MID_RST, PULSE_MAX_RST, PULSE_MIN_RST, COUNT_MIN_RST, COUNT_MAX_RST);
    test_random(60, 1, 17, 17);

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
